// ===== design/msbw_pkg.sv =====
// shared types, constants and helper functions of the multi-scale byte window sampler
package msbw_pkg;

  // fixed widths taken from the item and register fields
  localparam int unsigned SCALE_W   = 2;
  localparam int unsigned BYTES_W   = 16;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned ACTIVE_W  = 3;
  localparam int unsigned ACT_EFF_W = 4;
  localparam int unsigned CMP_W     = 7;
  localparam int unsigned LEN_REGS  = 4;

  localparam int unsigned DEF_SCALES       = 4;
  localparam int unsigned DEF_WINDOW_DEPTH = 32;

  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ACTIVE_SCALES = 3'd0,
    CFG_WINDOW_LEN_0  = 3'd1,
    CFG_WINDOW_LEN_1  = 3'd2,
    CFG_WINDOW_LEN_2  = 3'd3,
    CFG_WINDOW_LEN_3  = 3'd4
  } cfg_index_t;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd1;
  localparam logic [LEN_W-1:0]    LEN_RESET    = 6'd32;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_READ
  } back_state_t;

  typedef struct packed {
    logic [ACTIVE_W-1:0]            active_scales;
    logic [LEN_REGS-1:0][LEN_W-1:0] window_len;
  } cfg_t;

  typedef struct packed {
    opcode_t              op;
    logic                 err;
    logic [SCALE_W-1:0]   scale;
    logic [BYTES_W-1:0]   bytes;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [SCALE_W-1:0] scale;
    logic [LEN_W-1:0]   fill;
    logic [COUNT_W-1:0] window_bytes;
    logic               evicted_valid;
    logic [COUNT_W-1:0] evicted_bytes;
    logic               last;
    logic               error;
  } result_t;

  // active_scales clamped to the number of scales built
  function automatic logic [ACT_EFF_W-1:0] eff_active(input logic [ACTIVE_W-1:0] a,
                                                       input int unsigned scales);
    logic [ACT_EFF_W-1:0] s;
    s = ACT_EFF_W'(scales);
    if ({1'b0, a} > s) return s;
    return {1'b0, a};
  endfunction

  // window length: zero acts as one, clamp to ring depth
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n,
                                               input int unsigned depth);
    logic [CMP_W-1:0] d;
    d = CMP_W'(depth);
    if (n == '0) return LEN_W'(1);
    if ({1'b0, n} > d) return LEN_W'(d);
    return n;
  endfunction

endpackage

// ===== design/msbw_ram.sv =====
// generic single write, single read port ram with registered read data
module msbw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/msbw_queue.sv =====
// short command queue between the front end and the back end
module msbw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  msbw_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output msbw_pkg::cmd_t pop_cmd
);
  import msbw_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== design/msbw_front.sv =====
// front end: takes input requests, drops unused opcodes and flags inactive scales
module msbw_front #(
  parameter int unsigned SCALES = msbw_pkg::DEF_SCALES
) (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // scale[1:0], packet_bytes[17:2]
  input  logic [1:0]                      s_axis_tuser,  // opcode[1:0]
  input  logic [msbw_pkg::ACTIVE_W-1:0]   active_scales,
  output logic                            push_valid,
  input  logic                            push_ready,
  output msbw_pkg::cmd_t                  push_cmd
);
  import msbw_pkg::*;

  opcode_t              op;
  logic [ACT_EFF_W-1:0] act;

  assign op  = opcode_t'(s_axis_tuser[1:0]);
  assign act = eff_active(active_scales, SCALES);

  always_comb begin
    push_cmd.op    = op;
    push_cmd.scale = s_axis_tdata[1:0];
    push_cmd.bytes = s_axis_tdata[17:2];
    // tick and read of a scale not metered turn into a single error result
    push_cmd.err   = (op == OP_TICK || op == OP_READ) &&
                     ({{(ACT_EFF_W - SCALE_W){1'b0}}, s_axis_tdata[1:0]} >= act);
  end

  // unused opcode is taken and dropped here
  assign s_axis_tready = push_ready;
  assign push_valid    = s_axis_tvalid && (op != OP_NONE);

endmodule

// ===== design/msbw_back.sv =====
// back end: period counters, ring heads and fills, ring ram and result register
module msbw_back #(
  parameter int unsigned SCALES       = msbw_pkg::DEF_SCALES,
  parameter int unsigned WINDOW_DEPTH = msbw_pkg::DEF_WINDOW_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  msbw_pkg::cfg_t    cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  msbw_pkg::cmd_t    cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output msbw_pkg::result_t out_res
);
  import msbw_pkg::*;

  localparam int unsigned SIDX_W    = (SCALES > 1) ? $clog2(SCALES) : 1;
  localparam int unsigned HEAD_W    = $clog2(WINDOW_DEPTH);
  localparam int unsigned RAM_DEPTH = SCALES * WINDOW_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);

  back_state_t state;
  back_state_t state_next;

  logic [COUNT_W-1:0]   counter [SCALES];
  logic [HEAD_W-1:0]    head    [SCALES];
  logic [LEN_W-1:0]     fill    [SCALES];
  logic [RAM_DEPTH-1:0] written;

  // context of the request being carried out
  logic [SIDX_W-1:0]  cur_sidx;
  logic [SCALE_W-1:0] cur_scale;
  logic [LEN_W-1:0]   cur_len;
  logic [LEN_W-1:0]   cur_fill;
  logic [HEAD_W-1:0]  cur_idx;
  logic [LEN_W-1:0]   rd_left;

  logic [ACT_EFF_W-1:0] act;
  logic [SIDX_W-1:0]    sidx;
  logic [LEN_W-1:0]     len_c;
  logic [HEAD_W-1:0]    head_c;
  logic [LEN_W-1:0]     fill_c;
  logic [HEAD_W-1:0]    start_idx;
  logic [HEAD_W-1:0]    rd_idx_next;
  logic [LEN_W-1:0]     tick_fill;
  logic [ADDR_W-1:0]    cur_slot;

  logic               out_free;
  logic               out_load;
  result_t            out_next;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic               ram_we;
  logic [COUNT_W-1:0] ram_rdata;

  logic do_pkt;
  logic do_tick_start;
  logic do_read_start;
  logic do_tick_done;
  logic do_read_elem;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SIDX_W-1:0] s,
                                                  input logic [HEAD_W-1:0] i);
    return ADDR_W'(int'(s) * WINDOW_DEPTH + int'(i));
  endfunction

  function automatic logic [HEAD_W-1:0] wrap_inc(input logic [HEAD_W-1:0] i,
                                                 input logic [LEN_W-1:0] n);
    logic [CMP_W-1:0] nx;
    nx = CMP_W'(i) + CMP_W'(1);
    if (nx >= CMP_W'(n)) return '0;
    return HEAD_W'(nx);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] c,
                                                 input logic [BYTES_W-1:0] b);
    logic [COUNT_W:0] sum;
    sum = {1'b0, c} + (COUNT_W + 1)'(b);
    if (sum[COUNT_W]) return '1;
    return sum[COUNT_W-1:0];
  endfunction

  assign act      = eff_active(cfg.active_scales, SCALES);
  assign sidx     = SIDX_W'(cmd.scale);
  assign len_c    = eff_len(cfg.window_len[cmd.scale], WINDOW_DEPTH);
  // a head left beyond a shortened window restarts at slot zero
  assign head_c   = (CMP_W'(head[sidx]) >= CMP_W'(len_c)) ? '0 : head[sidx];
  assign fill_c   = (fill[sidx] > len_c) ? len_c : fill[sidx];
  assign start_idx = (fill_c < len_c) ? '0 : head_c;

  assign rd_idx_next = wrap_inc(cur_idx, cur_len);
  assign tick_fill   = (cur_fill < cur_len) ? cur_fill + LEN_W'(1) : cur_fill;
  assign cur_slot    = slot_addr(cur_sidx, cur_idx);
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    pop_ready     = 1'b0;
    out_load      = 1'b0;
    out_next      = '0;
    ram_re        = 1'b0;
    ram_raddr     = slot_addr(sidx, start_idx);
    ram_we        = 1'b0;
    do_pkt        = 1'b0;
    do_tick_start = 1'b0;
    do_read_start = 1'b0;
    do_tick_done  = 1'b0;
    do_read_elem  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          if (cmd.err) begin
            if (out_free) begin
              pop_ready      = 1'b1;
              out_load       = 1'b1;
              out_next.kind  = (cmd.op == OP_READ);
              out_next.scale = cmd.scale;
              out_next.last  = 1'b1;
              out_next.error = 1'b1;
            end
          end else begin
            pop_ready = 1'b1;
            case (cmd.op)
              OP_PACKET: begin
                do_pkt = 1'b1;
              end
              OP_TICK: begin
                do_tick_start = 1'b1;
                ram_re        = 1'b1;
                ram_raddr     = slot_addr(sidx, head_c);
                state_next    = ST_TICK;
              end
              OP_READ: begin
                do_read_start = 1'b1;
                if (fill_c != '0) begin
                  ram_re     = 1'b1;
                  ram_raddr  = slot_addr(sidx, start_idx);
                  state_next = ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_TICK: begin
        if (out_free) begin
          do_tick_done          = 1'b1;
          ram_we                = 1'b1;
          out_load              = 1'b1;
          out_next.kind         = 1'b0;
          out_next.scale        = cur_scale;
          out_next.fill         = tick_fill;
          out_next.window_bytes = counter[cur_sidx];
          out_next.evicted_valid = written[cur_slot];
          out_next.evicted_bytes = written[cur_slot] ? ram_rdata : '0;
          out_next.last         = 1'b1;
          state_next            = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          do_read_elem          = 1'b1;
          out_load              = 1'b1;
          out_next.kind         = 1'b1;
          out_next.scale        = cur_scale;
          out_next.fill         = cur_fill;
          out_next.window_bytes = ram_rdata;
          out_next.last         = (rd_left == LEN_W'(1));
          if (rd_left == LEN_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            // fetch the next element while this one goes out
            ram_re    = 1'b1;
            ram_raddr = slot_addr(cur_sidx, rd_idx_next);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SCALES; s++) begin
        counter[s] <= '0;
        head[s]    <= '0;
        fill[s]    <= '0;
      end
      written <= '0;
    end else begin
      if (do_pkt) begin
        for (int s = 0; s < SCALES; s++) begin
          if (ACT_EFF_W'(s) < act) begin
            counter[s] <= sat_add(counter[s], cmd.bytes);
          end
        end
      end
      if (do_read_start) begin
        head[sidx] <= head_c;
      end
      if (do_tick_done) begin
        counter[cur_sidx] <= '0;
        head[cur_sidx]    <= wrap_inc(cur_idx, cur_len);
        fill[cur_sidx]    <= tick_fill;
        written[cur_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick_start || do_read_start) begin
      cur_sidx  <= sidx;
      cur_scale <= cmd.scale;
      cur_len   <= len_c;
      cur_fill  <= fill_c;
      cur_idx   <= do_tick_start ? head_c : start_idx;
      rd_left   <= fill_c;
    end else if (do_read_elem) begin
      cur_idx <= rd_idx_next;
      rd_left <= rd_left - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= out_next;
    end
  end

  msbw_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_slot),
    .wdata (counter[cur_sidx]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/multi_scale_byte_window_sampler.sv =====
// top level of the multi-scale byte window sampler: config registers and stream ports
//
// Traffic meter over up to SCALES time scales, each with a ring of up to WINDOW_DEPTH
// period totals held in one ram. Requests enter a four-entry command queue, so the input
// side keeps taking requests while the back end works or the output is stalled, until the
// queue is full. The back end carries out one request at a time: a packet (all active
// counters add in parallel), an error result, a tick (registered ram read of the evicted
// slot, then write back), and a read, which sends one element per stored entry, the
// element stream being paced by the ram read port. There is no clearing pass after
// reset; slot written bits are held in flip-flops. Config writes are taken every cycle
// and must only be issued while the block is idle.
module multi_scale_byte_window_sampler #(
  parameter int unsigned SCALES       = msbw_pkg::DEF_SCALES,
  parameter int unsigned WINDOW_DEPTH = msbw_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msbw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [msbw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // scale[1:0], packet_bytes[17:2]
  input  logic [1:0]                        s_axis_tuser,  // opcode[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // scale_out[1:0], fill_count[7:2], window_bytes[39:8], evicted_valid[40],
  // evicted_bytes[72:41]
  output logic [79:0]                       m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,  // kind[0], error[1]
  output logic                              m_axis_tlast
);
  import msbw_pkg::*;

  cfg_t    cfg;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    push_valid;
  logic    push_ready;
  logic    pop_valid;
  logic    pop_ready;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_scales <= ACTIVE_RESET;
      for (int i = 0; i < LEN_REGS; i++) begin
        cfg.window_len[i] <= LEN_RESET;
      end
    end else if (cfg_valid) begin
      // writes beyond the register list are dropped
      case (cfg_index)
        CFG_ACTIVE_SCALES: cfg.active_scales <= cfg_data[ACTIVE_W-1:0];
        CFG_WINDOW_LEN_0:  cfg.window_len[0] <= cfg_data[LEN_W-1:0];
        CFG_WINDOW_LEN_1:  cfg.window_len[1] <= cfg_data[LEN_W-1:0];
        CFG_WINDOW_LEN_2:  cfg.window_len[2] <= cfg_data[LEN_W-1:0];
        CFG_WINDOW_LEN_3:  cfg.window_len[3] <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  msbw_front #(
    .SCALES (SCALES)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .active_scales (cfg.active_scales),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  msbw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  msbw_back #(
    .SCALES       (SCALES),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {7'b0, res.evicted_bytes, res.evicted_valid, res.window_bytes,
                         res.fill, res.scale};
  assign m_axis_tuser = {res.error, res.kind};
  assign m_axis_tlast = res.last;

endmodule

// ===== bench/tb.sv =====
// self-checking stream testbench for the multi-scale byte window sampler
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msbw_pkg::*;

  localparam int SCALES        = DEF_SCALES;
  localparam int WINDOW_DEPTH  = DEF_WINDOW_DEPTH;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_WAIT   = 32;
  localparam int BURST_PACKETS = 16;
  localparam int SHOW_LIMIT    = 20;

  typedef struct {
    opcode_t              op;
    logic [SCALE_W-1:0]   scale;
    logic [BYTES_W-1:0]   nbytes;
    int unsigned          hold_off;
  } meter_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // scale[1:0], packet_bytes[17:2]
  logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // scale_out, fill_count, window_bytes, evicted_valid, evicted_bytes
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;        // kind[0], error[1]
  logic        m_axis_tlast;

  multi_scale_byte_window_sampler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // meter state as the block should hold it
  logic [COUNT_W-1:0] period_sum [SCALES];
  logic [COUNT_W-1:0] ring_vals [SCALES][WINDOW_DEPTH];
  bit                 ring_used [SCALES][WINDOW_DEPTH];
  int unsigned        ring_pos [SCALES];
  int unsigned        ring_cnt [SCALES];
  logic [ACTIVE_W-1:0] scales_reg = ACTIVE_RESET;
  logic [LEN_W-1:0]    span_reg [LEN_REGS] = '{LEN_RESET, LEN_RESET, LEN_RESET, LEN_RESET};

  bit          read_ok [SCALES] = '{1'b1, 1'b1, 1'b1, 1'b1};
  meter_req_t  req_backlog [$];
  result_t     due_results [$];
  meter_req_t  on_wire;
  int unsigned waited = 0;
  int unsigned out_hold = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  int          reqs_queued = 0;
  int          reqs_taken = 0;
  int          results_seen = 0;
  int          n_reports = 0;
  int          n_elems = 0;
  int          n_errs = 0;
  int          fail_count = 0;
  int          quiet = 0;

  initial begin
    for (int s = 0; s < SCALES; s++) begin
      period_sum[s] = '0;
      ring_pos[s] = 0;
      ring_cnt[s] = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring_vals[s][i] = '0;
        ring_used[s][i] = 1'b0;
      end
    end
  end

  function automatic int unsigned live_scales();
    return (scales_reg > SCALES) ? SCALES : scales_reg;
  endfunction

  function automatic int unsigned span_of(input int s);
    if (span_reg[s] == '0) return 1;
    if (span_reg[s] > WINDOW_DEPTH) return WINDOW_DEPTH;
    return span_reg[s];
  endfunction

  // a ring is safe to read back while every slot a read can reach holds a period total
  function automatic bit ring_consistent(input int s);
    int unsigned len, cnt, pos;
    len = span_of(s);
    cnt = (ring_cnt[s] > len) ? len : ring_cnt[s];
    pos = (ring_pos[s] >= len) ? 0 : ring_pos[s];
    for (int i = 0; i < cnt; i++)
      if (!ring_used[s][i]) return 1'b0;
    return (cnt == len) || (pos == cnt);
  endfunction

  task automatic predict_meter(input meter_req_t r);
    int unsigned act, len, pos, cnt, slot, sc;
    logic [COUNT_W:0] sum;
    result_t res;
    act = live_scales();
    sc = r.scale;
    if (r.op == OP_PACKET) begin
      for (int i = 0; i < act; i++) begin
        sum = {1'b0, period_sum[i]} + r.nbytes;
        period_sum[i] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
      end
      return;
    end
    if (r.op == OP_NONE) return;
    res = '0;
    res.kind = (r.op == OP_READ);
    res.scale = r.scale;
    if (sc >= act) begin
      res.last = 1'b1;
      res.error = 1'b1;
      due_results.push_back(res);
      return;
    end
    len = span_of(sc);
    pos = (ring_pos[sc] >= len) ? 0 : ring_pos[sc];
    cnt = (ring_cnt[sc] > len) ? len : ring_cnt[sc];
    if (r.op == OP_TICK) begin
      res.evicted_valid = ring_used[sc][pos];
      res.evicted_bytes = ring_used[sc][pos] ? ring_vals[sc][pos] : '0;
      if (cnt < len) cnt++;
      res.fill = LEN_W'(cnt);
      res.window_bytes = period_sum[sc];
      res.last = 1'b1;
      ring_vals[sc][pos] = period_sum[sc];
      ring_used[sc][pos] = 1'b1;
      pos++;
      if (pos >= len) pos = 0;
      ring_pos[sc] = pos;
      ring_cnt[sc] = cnt;
      period_sum[sc] = '0;
      due_results.push_back(res);
    end else begin
      ring_pos[sc] = pos;
      // oldest entry sits at slot 0 until the ring has wrapped
      slot = (cnt < len) ? 0 : pos;
      for (int i = 0; i < cnt; i++) begin
        res.fill = LEN_W'(cnt);
        res.window_bytes = ring_used[sc][slot] ? ring_vals[sc][slot] : '0;
        res.last = (i + 1 == cnt);
        due_results.push_back(res);
        slot++;
        if (slot >= len) slot = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    bit took;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      waited = 0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        predict_meter(on_wire);
        reqs_taken++;
      end
      if (!s_axis_tvalid || took) begin
        if (req_backlog.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (waited < req_backlog[0].hold_off) begin
          waited++;
          s_axis_tvalid <= 1'b0;
        end else begin
          on_wire = req_backlog.pop_front();
          waited = 0;
          s_axis_tdata <= {6'b0, on_wire.nbytes, on_wire.scale};
          s_axis_tuser <= on_wire.op;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_results
    result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser[0];
        got.error = m_axis_tuser[1];
        got.scale = m_axis_tdata[1:0];
        got.fill = m_axis_tdata[7:2];
        got.window_bytes = m_axis_tdata[39:8];
        got.evicted_valid = m_axis_tdata[40];
        got.evicted_bytes = m_axis_tdata[72:41];
        got.last = m_axis_tlast;
        if (due_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = due_results.pop_front();
          check_field("kind", got.kind, want.kind);
          check_field("scale_out", got.scale, want.scale);
          check_field("fill_count", got.fill, want.fill);
          check_field("window_bytes", got.window_bytes, want.window_bytes);
          check_field("evicted_valid", got.evicted_valid, want.evicted_valid);
          check_field("evicted_bytes", got.evicted_bytes, want.evicted_bytes);
          check_field("last", got.last, want.last);
          check_field("error", got.error, want.error);
        end
        if (got.error) n_errs++;
        else if (got.kind) n_elems++;
        else n_reports++;
        results_seen++;
        if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
        out_hold = calm_out ? 0 : $urandom_range(0, 9);
      end
      if (out_hold > 0) begin
        out_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // starts right after a rising edge; leaves cfg_valid high for the caller to drop
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_ACTIVE_SCALES) scales_reg = val[ACTIVE_W-1:0];
    else if (idx >= CFG_WINDOW_LEN_0 && idx <= CFG_WINDOW_LEN_3)
      span_reg[idx - CFG_WINDOW_LEN_0] = val;
  endtask

  // indexes past the register list must be ignored
  task automatic write_spares();
    for (int k = CFG_WINDOW_LEN_3 + 1; k < (1 << CFG_INDEX_W); k++)
      write_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] act, input logic [CFG_DATA_W-1:0] l0,
                          input logic [CFG_DATA_W-1:0] l1, input logic [CFG_DATA_W-1:0] l2,
                          input logic [CFG_DATA_W-1:0] l3, input bit spares);
    write_reg(CFG_ACTIVE_SCALES, act);
    write_reg(CFG_WINDOW_LEN_0, l0);
    write_reg(CFG_WINDOW_LEN_1, l1);
    write_reg(CFG_WINDOW_LEN_2, l2);
    write_reg(CFG_WINDOW_LEN_3, l3);
    if (spares) write_spares();
    cfg_valid <= 1'b0;
    for (int s = 0; s < SCALES; s++) read_ok[s] = ring_consistent(s);
  endtask

  task automatic push_req(input opcode_t op, input logic [SCALE_W-1:0] sc,
                          input logic [BYTES_W-1:0] nb, input bit eager);
    meter_req_t r;
    // a read that could reach a never written slot becomes a tick
    if (op == OP_READ && sc < live_scales() && !read_ok[sc]) op = OP_TICK;
    if ($urandom_range(0, 15) == 0) calm_in = !calm_in;
    r.op = op;
    r.scale = sc;
    r.nbytes = nb;
    r.hold_off = (eager || calm_in) ? 0 : $urandom_range(0, 9);
    req_backlog.push_back(r);
    reqs_queued++;
  endtask

  task automatic queue_random(input int n);
    int j, k, runs;
    logic [SCALE_W-1:0] sc;
    logic [BYTES_W-1:0] nb;
    opcode_t op;
    j = 0;
    while (j < n) begin
      sc = SCALE_W'($urandom_range(0, SCALES - 1));
      if ($urandom_range(0, 19) == 0) begin
        // tick one ring a random number of times, possibly far enough to wrap, then read it back
        runs = $urandom_range(5, 34);
        for (k = 0; k < runs; k++) begin
          push_req(OP_PACKET, SCALE_W'($urandom), BYTES_W'($urandom), 1'b0);
          push_req(OP_TICK, sc, BYTES_W'($urandom), 1'b0);
        end
        push_req(OP_READ, sc, BYTES_W'($urandom), 1'b0);
        j += 2 * runs + 1;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 40) op = OP_PACKET;
        else if (k < 72) op = OP_TICK;
        else if (k < 93) op = OP_READ;
        else op = OP_NONE;
        case ($urandom_range(0, 7))
          0: nb = '0;
          1: nb = '1;
          default: nb = BYTES_W'($urandom);
        endcase
        push_req(op, sc, nb, 1'b0);
        j++;
      end
    end
  endtask

  // wait until every request is taken and every result is back, then let the queue drain
  task automatic settle();
    do @(posedge clk);
    while (reqs_taken != reqs_queued || due_results.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one scale, full-length windows
    write_spares();
    cfg_valid <= 1'b0;
    push_req(OP_READ, 0, 16'h0000, 1'b0);
    push_req(OP_READ, 1, 16'h1234, 1'b0);
    push_req(OP_TICK, 3, 16'hFFFF, 1'b0);
    push_req(OP_NONE, 2, 16'h5A5A, 1'b0);
    push_req(OP_PACKET, 0, 16'h0000, 1'b0);
    push_req(OP_PACKET, 3, 16'hFFFF, 1'b0);
    push_req(OP_TICK, 0, 16'h0000, 1'b0);
    push_req(OP_READ, 0, 16'h0000, 1'b0);
    queue_random(30);
    settle();

    // all scales, lengths zero and over range; a back-to-back burst of full-size packets
    set_regs(4, 0, 63, 33, 2, 1'b0);
    for (int i = 0; i < BURST_PACKETS; i++) push_req(OP_PACKET, 0, 16'hFFFF, 1'b1);
    for (int s = 0; s < SCALES; s++) push_req(OP_TICK, s, 16'h0000, 1'b0);
    push_req(OP_TICK, 0, 16'h0000, 1'b0);
    push_req(OP_READ, 0, 16'h0000, 1'b0);
    push_req(OP_TICK, 3, 16'h0000, 1'b0);
    push_req(OP_TICK, 3, 16'h0000, 1'b0);
    push_req(OP_READ, 3, 16'h0000, 1'b0);
    repeat (5) push_req(OP_TICK, 1, 16'h0000, 1'b0);
    settle();

    // window shrunk under the head and below the fill; active count above the scales built
    set_regs(7, 1, 3, 33, 2, 1'b1);
    push_req(OP_READ, 1, 16'h0000, 1'b0);
    push_req(OP_TICK, 1, 16'h0000, 1'b0);
    push_req(OP_READ, 1, 16'h0000, 1'b0);
    queue_random(70);
    settle();

    // no scale active
    set_regs(0, 1, 3, 1, 32, 1'b0);
    push_req(OP_TICK, 0, 16'h0000, 1'b0);
    push_req(OP_READ, 2, 16'h0000, 1'b0);
    push_req(OP_PACKET, 1, 16'hFFFF, 1'b0);
    queue_random(20);
    settle();

    set_regs(2, 5, 6, 1, 32, 1'b0);
    queue_random(70);
    settle();

    set_regs(3, 32, 1, 17, 40, 1'b0);
    queue_random(70);
    settle();

    set_regs(4, 31, 32, 2, 9, 1'b0);
    queue_random(90);
    settle();

    set_regs(1, 32, 32, 32, 32, 1'b0);
    queue_random(40);
    settle();

    $display("ran %0d requests through 8 register settings and checked %0d results",
             reqs_taken, results_seen);
    $display("%0d tick reports, %0d window elements, %0d error results",
             n_reports, n_elems, n_errs);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
